// File: hw/rtl/qibu_pkg.sv
// Shared types and constants for the quantum-inspired probability update block.
package qibu_pkg;

	localparam int NUM_STOCKS_DEF         = 64;
	localparam int PROB_FRACTION_BITS_DEF = 16;
	localparam int ANGLE_W                = 13;
	localparam int FIT_W                  = 32;
	localparam int VEC_W                  = 64;
	localparam int IDX_W                  = 6;

	localparam logic [ANGLE_W-1:0]      ANGLE_RESET = 13'd26;
	localparam logic signed [FIT_W-1:0] SCORE_MIN   = 32'sh8000_0000;
	localparam logic signed [FIT_W-1:0] SCORE_MAX   = 32'sh7FFF_FFFF;

	typedef enum logic [1:0] {
		CMD_SAMPLE = 2'd0,
		CMD_REPORT = 2'd1,
		CMD_UPDATE = 2'd2,
		CMD_NOP    = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE   = 2'd0,
		ST_SAMP   = 2'd1,
		ST_UPD_RD = 2'd2,
		ST_UPD_WR = 2'd3
	} state_t;

	typedef struct packed {
		logic [1:0]              command;
		logic [15:0]             random_fraction;
		logic signed [FIT_W-1:0] fitness;
	} qibu_in_t;

	typedef struct packed {
		logic                    sampled_bit;
		logic [IDX_W-1:0]        stock_index;
		logic                    new_best;
		logic signed [FIT_W-1:0] best_fitness;
		logic [VEC_W-1:0]        best_vector;
	} qibu_out_t;

	typedef struct packed {
		logic best_bit;
		logic worst_bit;
	} rot_sel_t;

endpackage

// File: hw/rtl/qibu_ram.sv
// Generic single-write, single-read RAM with registered read data.
module qibu_ram #(
	parameter int WIDTH = 17,
	parameter int DEPTH = 64,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: hw/rtl/qibu_rotate.sv
// Probability rotation unit: mirror across one half, then step by the angle with saturation.
module qibu_rotate #(
	parameter int PROB_FRACTION_BITS = qibu_pkg::PROB_FRACTION_BITS_DEF,
	parameter int PW                 = PROB_FRACTION_BITS + 1
) (
	input  logic [PW-1:0]     prob,
	input  logic [PW-1:0]     angle,
	input  qibu_pkg::rot_sel_t sel,
	output logic [PW-1:0]     prob_nxt
);
	import qibu_pkg::*;

	localparam logic [PW-1:0] ONE  = PW'(1) << PROB_FRACTION_BITS;
	localparam logic [PW-1:0] HALF = PW'(1) << (PROB_FRACTION_BITS - 1);

	logic [PW-1:0] pm_dn;
	logic [PW-1:0] res_dn;
	logic [PW-1:0] pm_up;
	logic [PW-1:0] res_up;

	always_comb begin
		pm_dn  = (prob > HALF) ? ONE - prob : prob;
		res_dn = (pm_dn > angle) ? pm_dn - angle : '0;
		pm_up  = (prob < HALF) ? ONE - prob : prob;
		res_up = ((ONE - pm_up) > angle) ? pm_up + angle : ONE;
		if (!sel.best_bit && sel.worst_bit) begin
			prob_nxt = res_dn;
		end else if (sel.best_bit && !sel.worst_bit) begin
			prob_nxt = res_up;
		end else begin
			prob_nxt = prob;
		end
	end

endmodule

// File: hw/rtl/quantum_inspired_beta_update_top.sv
// Top level of the quantum-inspired probability update block.
// Keeps one selection probability per stock in a RAM and answers three commands, one result word
// per command word. A report (and the unused command code) registers its result straight from
// the command word; a sample waits for the probability from the RAM's registered read port; an
// update visits every entry in turn, as the single rotation unit reads and then writes back one
// probability per entry through that one RAM. A new command word is taken only when the block is
// idle and the result register is empty or being emptied. Probabilities read as one half until
// first written, so no clearing pass follows reset.
module quantum_inspired_beta_update_top #(
	parameter int NUM_STOCKS         = qibu_pkg::NUM_STOCKS_DEF,
	parameter int PROB_FRACTION_BITS = qibu_pkg::PROB_FRACTION_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [qibu_pkg::ANGLE_W-1:0]    cfg_wdata,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  qibu_pkg::qibu_in_t              in_data,
	output logic                            out_valid,
	input  logic                            out_ready,
	output qibu_pkg::qibu_out_t             out_data
);
	import qibu_pkg::*;

	localparam int PW  = PROB_FRACTION_BITS + 1;
	localparam int IW  = (NUM_STOCKS > 1) ? $clog2(NUM_STOCKS) : 1;
	localparam int SHL = (PROB_FRACTION_BITS >= 16) ? PROB_FRACTION_BITS - 16 : 0;
	localparam int SHR = (PROB_FRACTION_BITS < 16) ? 16 - PROB_FRACTION_BITS : 0;
	localparam logic [PW-1:0] HALF = PW'(1) << (PROB_FRACTION_BITS - 1);
	localparam logic [IW-1:0] LAST = IW'(NUM_STOCKS - 1);

	state_t                  state_q, state_nxt;
	logic [ANGLE_W-1:0]      angle_q;
	logic [15:0]             rnd_q;
	logic [IW-1:0]           pos_q;
	logic [IW-1:0]           idx_q;
	logic [NUM_STOCKS-1:0]   cand_q;
	logic [NUM_STOCKS-1:0]   best_bits_q;
	logic signed [FIT_W-1:0] best_score_q;
	logic [NUM_STOCKS-1:0]   worst_bits_q;
	logic signed [FIT_W-1:0] worst_score_q;
	logic [NUM_STOCKS-1:0]   valid_q;
	logic                    rd_valid_q;
	logic                    out_valid_q;
	qibu_out_t               out_data_q;

	logic                    accept;
	cmd_t                    cmd;
	logic                    rd_en;
	logic [IW-1:0]           rd_addr;
	logic                    wr_en;
	logic                    samp_done;
	logic                    do_report;
	logic                    do_nop;
	logic                    upd_start;
	logic                    upd_last;
	logic                    ld_out;

	logic [PW-1:0]           ram_rdata;
	logic [PW-1:0]           prob_rd;
	logic [PW-1:0]           prob_wr;
	logic [PW+12:0]          ang_ext;
	logic [PW-1:0]           angle;
	logic [PW+15:0]          rnd_ext;
	logic [PW-1:0]           rnd_scaled;
	logic                    samp_bit;
	rot_sel_t                sel;

	logic                    beat_best;
	logic                    beat_worst;
	logic signed [FIT_W-1:0] best_score_nxt;
	logic [NUM_STOCKS-1:0]   best_bits_nxt;
	qibu_out_t               out_nxt;

	assign accept   = in_valid && in_ready;
	assign cmd      = cmd_t'(in_data.command);
	assign in_ready = (state_q == ST_IDLE) && (!out_valid_q || out_ready);

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && cmd == CMD_SAMPLE) begin
					state_nxt = ST_SAMP;
				end else if (accept && cmd == CMD_UPDATE) begin
					state_nxt = ST_UPD_RD;
				end
			end
			ST_SAMP:   state_nxt = ST_IDLE;
			ST_UPD_RD: state_nxt = ST_UPD_WR;
			ST_UPD_WR: state_nxt = (idx_q == LAST) ? ST_IDLE : ST_UPD_RD;
			default:   state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		rd_en     = 1'b0;
		rd_addr   = pos_q;
		wr_en     = 1'b0;
		samp_done = 1'b0;
		do_report = 1'b0;
		do_nop    = 1'b0;
		upd_start = 1'b0;
		upd_last  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (cmd)
						CMD_SAMPLE: rd_en     = 1'b1;
						CMD_REPORT: do_report = 1'b1;
						CMD_UPDATE: upd_start = 1'b1;
						default:    do_nop    = 1'b1;
					endcase
				end
			end
			ST_SAMP: samp_done = 1'b1;
			ST_UPD_RD: begin
				rd_en   = 1'b1;
				rd_addr = idx_q;
			end
			ST_UPD_WR: begin
				wr_en    = 1'b1;
				upd_last = (idx_q == LAST);
			end
			default: ;
		endcase
	end

	assign ld_out = samp_done || do_report || do_nop || upd_last;

	qibu_ram #(
		.WIDTH(PW),
		.DEPTH(NUM_STOCKS),
		.AW   (IW)
	) u_prob_ram (
		.clk  (clk),
		.we   (wr_en),
		.waddr(idx_q),
		.wdata(prob_wr),
		.re   (rd_en),
		.raddr(rd_addr),
		.rdata(ram_rdata)
	);

	assign prob_rd    = rd_valid_q ? ram_rdata : HALF;
	assign ang_ext    = {{PW{1'b0}}, angle_q};
	assign angle      = PW'((ang_ext << SHL) >> SHR);
	assign rnd_ext    = {{PW{1'b0}}, rnd_q};
	assign rnd_scaled = PW'((rnd_ext << SHL) >> SHR);
	assign samp_bit   = rnd_scaled < prob_rd;

	assign sel.best_bit  = best_bits_q[idx_q];
	assign sel.worst_bit = worst_bits_q[idx_q];

	qibu_rotate #(
		.PROB_FRACTION_BITS(PROB_FRACTION_BITS),
		.PW                (PW)
	) u_rotate (
		.prob    (prob_rd),
		.angle   (angle),
		.sel     (sel),
		.prob_nxt(prob_wr)
	);

	always_comb begin
		beat_best      = in_data.fitness > best_score_q;
		beat_worst     = in_data.fitness < worst_score_q;
		best_score_nxt = best_score_q;
		best_bits_nxt  = best_bits_q;
		if (do_report && beat_best) begin
			if (in_data.fitness < 0) begin
				best_score_nxt = '0;
				best_bits_nxt  = '0;
			end else begin
				best_score_nxt = in_data.fitness;
				best_bits_nxt  = cand_q;
			end
		end
		out_nxt.sampled_bit  = samp_done && samp_bit;
		out_nxt.stock_index  = samp_done ? IDX_W'(pos_q) : '0;
		out_nxt.new_best     = do_report && beat_best;
		out_nxt.best_fitness = best_score_nxt;
		out_nxt.best_vector  = VEC_W'(best_bits_nxt);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			angle_q       <= ANGLE_RESET;
			pos_q         <= '0;
			idx_q         <= '0;
			cand_q        <= '0;
			best_bits_q   <= '0;
			best_score_q  <= SCORE_MIN;
			worst_bits_q  <= '0;
			worst_score_q <= SCORE_MAX;
			valid_q       <= '0;
			rd_valid_q    <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cfg_we) begin
				angle_q <= cfg_wdata;
			end
			if (rd_en) begin
				rd_valid_q <= valid_q[rd_addr];
			end
			if (samp_done) begin
				cand_q[pos_q] <= samp_bit;
				pos_q         <= (pos_q == LAST) ? '0 : pos_q + IW'(1);
			end
			if (do_report) begin
				best_score_q <= best_score_nxt;
				best_bits_q  <= best_bits_nxt;
				pos_q        <= '0;
				if (beat_worst) begin
					worst_score_q <= in_data.fitness;
					worst_bits_q  <= cand_q;
				end
			end
			if (upd_start) begin
				idx_q <= '0;
			end
			if (wr_en) begin
				valid_q[idx_q] <= 1'b1;
				idx_q          <= idx_q + IW'(1);
			end
			if (upd_last) begin
				worst_score_q <= SCORE_MAX;
				pos_q         <= '0;
			end
			if (ld_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rnd_q <= in_data.random_fraction;
		end
		if (ld_out) begin
			out_data_q <= out_nxt;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	a_samp_result: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SAMP |=> out_valid_q)
		else $error("sample finished without a result word");

	a_upd_walk: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_UPD_RD |=> state_q == ST_UPD_WR && $stable(idx_q))
		else $error("update walk lost its entry");

	a_best_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |=> $signed(best_score_q) >= $signed($past(best_score_q)))
		else $error("global best score decreased");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPD_WR && idx_q != LAST) |=> !in_ready)
		else $error("command word taken during update walk");

endmodule
